// ----- design/wcsp_pkg.sv -----
package wcsp_pkg;

    localparam int WAVE_BYTES = 16;
    localparam int WAVE_AW    = $clog2(WAVE_BYTES);
    localparam int SAMPLES    = 2 * WAVE_BYTES;
    localparam int POS_W      = $clog2(SAMPLES);
    localparam int PERIOD_W   = 11;
    localparam int COUNT_W    = PERIOD_W + 1;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [7:0] ADDR_DAC     = 8'h1A;
    localparam logic [7:0] ADDR_LENGTH  = 8'h1B;
    localparam logic [7:0] ADDR_VOLUME  = 8'h1C;
    localparam logic [7:0] ADDR_PER_LO  = 8'h1D;
    localparam logic [7:0] ADDR_PER_HI  = 8'h1E;
    localparam logic [3:0] WAVE_PAGE    = 4'h3;
    localparam logic [7:0] OPEN_BUS     = 8'hFF;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] reg_address;
        logic [7:0] write_data;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] sample_out;
        logic       channel_on;
    } t_result;

    // control values the sample generator needs from the register file
    typedef struct packed {
        logic [PERIOD_W-1:0] reload;
        logic [1:0]          vol_code;
    } t_ctrl;

endpackage

// ----- design/wcsp_if.sv -----
interface wcsp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] reg_address;
    logic [7:0] write_data;

    modport source (output valid, output opcode, output reg_address, output write_data,
                    input ready);
    modport sink   (input valid, input opcode, input reg_address, input write_data,
                    output ready);
endinterface

interface wcsp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [3:0] sample_out;
    logic       channel_on;

    modport source (output valid, output read_data, output sample_out, output channel_on,
                    input ready);
    modport sink   (input valid, input read_data, input sample_out, input channel_on,
                    output ready);
endinterface

// ----- design/wcsp_regfile.sv -----
module wcsp_regfile (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [1:0]                   i_opcode,
    input  logic [7:0]                   i_addr,
    input  logic [7:0]                   i_data,
    input  logic [wcsp_pkg::WAVE_AW-1:0] i_wave_idx,
    output logic [7:0]                   o_wave_byte,
    output wcsp_pkg::t_ctrl              o_ctrl,
    output logic [7:0]                   o_rd_data,
    output logic                         o_playing_next
);

    logic [7:0] r_wave [wcsp_pkg::WAVE_BYTES];
    logic [7:0] r_dac;
    logic [7:0] r_volume;
    logic [7:0] r_per_lo;
    logic [7:0] r_per_hi;
    logic       r_playing;

    logic                         is_wave;
    logic                         do_write;
    logic [wcsp_pkg::WAVE_AW-1:0] rd_idx;
    logic [7:0]                   rd_byte;

    assign is_wave  = (i_addr[7:4] == wcsp_pkg::WAVE_PAGE);
    assign do_write = i_en && (i_opcode == wcsp_pkg::OP_WRITE);

    // one read port shared by bus reads and sample fetch
    assign rd_idx  = (i_opcode == wcsp_pkg::OP_READ) ? i_addr[wcsp_pkg::WAVE_AW-1:0]
                                                      : i_wave_idx;
    assign rd_byte = r_wave[rd_idx];

    assign o_wave_byte     = rd_byte;
    assign o_ctrl.reload   = {r_per_hi[2:0], r_per_lo};
    assign o_ctrl.vol_code = r_volume[6:5];

    always_comb begin
        o_rd_data = wcsp_pkg::OPEN_BUS;
        if (i_opcode == wcsp_pkg::OP_READ) begin
            if (is_wave) begin
                o_rd_data = rd_byte;
            end else begin
                case (i_addr)
                    wcsp_pkg::ADDR_DAC:    o_rd_data = r_dac;
                    wcsp_pkg::ADDR_VOLUME: o_rd_data = r_volume;
                    wcsp_pkg::ADDR_PER_HI: o_rd_data = r_per_hi;
                    default:               o_rd_data = wcsp_pkg::OPEN_BUS;
                endcase
            end
        end
    end

    always_comb begin
        o_playing_next = r_playing;
        if (do_write && !is_wave) begin
            case (i_addr)
                wcsp_pkg::ADDR_DAC: begin
                    if (!i_data[7]) o_playing_next = 1'b0;
                end
                wcsp_pkg::ADDR_PER_HI: begin
                    if (i_data[7] && r_dac[7]) o_playing_next = 1'b1;
                end
                default: o_playing_next = r_playing;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < wcsp_pkg::WAVE_BYTES; i++) r_wave[i] <= 8'h00;
            r_dac     <= 8'h00;
            r_volume  <= 8'h00;
            r_per_lo  <= 8'h00;
            r_per_hi  <= 8'h00;
            r_playing <= 1'b0;
        end else begin
            if (i_en) r_playing <= o_playing_next;
            if (do_write) begin
                if (is_wave) begin
                    r_wave[i_addr[wcsp_pkg::WAVE_AW-1:0]] <= i_data;
                end else begin
                    case (i_addr)
                        wcsp_pkg::ADDR_DAC:    r_dac    <= i_data;
                        wcsp_pkg::ADDR_VOLUME: r_volume <= i_data;
                        wcsp_pkg::ADDR_PER_LO: r_per_lo <= i_data;
                        wcsp_pkg::ADDR_PER_HI: r_per_hi <= i_data;
                        // length register has no timer behind it
                        wcsp_pkg::ADDR_LENGTH: r_per_lo <= r_per_lo;
                        default:               r_per_lo <= r_per_lo;
                    endcase
                end
            end
        end
    end

    a_play_needs_dac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing |-> r_dac[7])
        else $error("channel active with dac off");

    a_dac_off_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_write && !is_wave && (i_addr == wcsp_pkg::ADDR_DAC) && !i_data[7] |=> !r_playing)
        else $error("dac clear did not stop channel");

    a_read_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_opcode != wcsp_pkg::OP_READ) |-> (o_rd_data == wcsp_pkg::OPEN_BUS))
        else $error("read data driven on non-read beat");

endmodule

// ----- design/wcsp_gen.sv -----
module wcsp_gen (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_tick,
    input  wcsp_pkg::t_ctrl              i_ctrl,
    input  logic [7:0]                   i_wave_byte,
    output logic [wcsp_pkg::WAVE_AW-1:0] o_wave_idx,
    output logic [3:0]                   o_sample_next
);

    logic [1:0]                   r_phase;
    logic [wcsp_pkg::COUNT_W-1:0] r_count;
    logic [wcsp_pkg::POS_W-1:0]   r_pos;
    logic [3:0]                   r_sample;

    logic [1:0]                   n_phase;
    logic [wcsp_pkg::COUNT_W-1:0] n_count;
    logic [wcsp_pkg::COUNT_W-1:0] count_inc;
    logic [wcsp_pkg::COUNT_W-1:0] reload_ext;
    logic [wcsp_pkg::POS_W-1:0]   n_pos;
    logic [3:0]                   nib;
    logic [3:0]                   scaled;
    logic                         fetch;

    assign o_wave_idx = r_pos[wcsp_pkg::POS_W-1:1];
    assign reload_ext = {1'b0, i_ctrl.reload};
    assign count_inc  = r_count + 1'b1;

    // high nibble first
    assign nib = r_pos[0] ? i_wave_byte[3:0] : i_wave_byte[7:4];

    always_comb begin
        case (i_ctrl.vol_code)
            2'd0:    scaled = 4'd0;
            2'd1:    scaled = nib;
            2'd2:    scaled = nib >> 1;
            2'd3:    scaled = nib >> 2;
            default: scaled = 4'd0;
        endcase
    end

    always_comb begin
        n_phase       = r_phase + 2'd1;
        n_count       = r_count;
        n_pos         = r_pos;
        o_sample_next = r_sample;
        fetch         = (n_phase == 2'd1) && (r_count == reload_ext);
        if (i_tick) begin
            if (fetch) begin
                o_sample_next = scaled;
                n_pos         = r_pos + 1'b1;
            end
            if (n_phase == 2'd2) begin
                // counter runs at half the tick rate and reloads at overflow of 11 bits
                n_count = count_inc[wcsp_pkg::COUNT_W-1] ? reload_ext : count_inc;
                n_phase = 2'd0;
            end
        end else begin
            n_phase = r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= 2'd0;
            r_count  <= '0;
            r_pos    <= '0;
            r_sample <= 4'd0;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_pos    <= n_pos;
            r_sample <= o_sample_next;
        end
    end

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_count[wcsp_pkg::COUNT_W-1])
        else $error("period counter past reload point");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("divider phase out of range");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_tick |=> $stable(r_phase) && $stable(r_count) && $stable(r_pos) && $stable(r_sample))
        else $error("generator state moved without a tick");

endmodule

// ----- design/wave_channel_sample_player.sv -----
// wave channel sample player
// input channel i_in carries one operation per beat: opcode 0 advances the
// channel by one tick, 1 reads the byte at reg_address, 2 writes write_data
// there (0x1A dac, 0x1B length, 0x1C volume, 0x1D/0x1E period and trigger,
// 0x30..0x3F wave ram). opcode 3 does nothing.
// output channel o_out returns exactly one beat per input beat, in order:
// read_data (0xFF unless a read of a readable address), the current sample
// after the volume shift, and the channel active flag, all as they stand
// after the operation.
// output valid rises once the beat has moved on from the input register: the
// beat sits in the input register, and is applied to the state as the result
// register is loaded; a stalled receiver keeps it waiting in the input register.
// throughput is one beat per cycle while the receiver takes results; the wave
// ram has a single read port shared by bus reads and sample fetch.
// reset clears wave ram, control bytes, divider, period counter, sample
// index and output sample; both channels come up empty.
// when the receiver stalls, the result register holds its beat and the
// input register holds one more, then i_in.ready drops.
module wave_channel_sample_player (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wcsp_in_if.sink           i_in,
    wcsp_out_if.source        o_out
);

    logic              r_in_valid;
    wcsp_pkg::t_item   r_in;
    logic              r_out_valid;
    wcsp_pkg::t_result r_out;

    logic                         out_free;
    logic                         adv;
    logic                         tick;
    logic [wcsp_pkg::WAVE_AW-1:0] wave_idx;
    logic [7:0]                   wave_byte;
    wcsp_pkg::t_ctrl              ctrl;
    logic [7:0]                   rd_data;
    logic                         playing_next;
    logic [3:0]                   sample_next;

    assign out_free   = !r_out_valid || o_out.ready;
    assign adv        = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || adv;
    assign tick       = adv && (r_in.opcode == wcsp_pkg::OP_TICK);

    wcsp_regfile u_regfile (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (adv),
        .i_opcode       (r_in.opcode),
        .i_addr         (r_in.reg_address),
        .i_data         (r_in.write_data),
        .i_wave_idx     (wave_idx),
        .o_wave_byte    (wave_byte),
        .o_ctrl         (ctrl),
        .o_rd_data      (rd_data),
        .o_playing_next (playing_next)
    );

    wcsp_gen u_gen (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (tick),
        .i_ctrl        (ctrl),
        .i_wave_byte   (wave_byte),
        .o_wave_idx    (wave_idx),
        .o_sample_next (sample_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) r_in_valid <= i_in.valid;
            if (out_free)   r_out_valid <= adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.opcode      <= i_in.opcode;
            r_in.reg_address <= i_in.reg_address;
            r_in.write_data  <= i_in.write_data;
        end
        if (adv) begin
            r_out.read_data  <= rd_data;
            r_out.sample_out <= sample_next;
            r_out.channel_on <= playing_next;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_data  = r_out.read_data;
    assign o_out.sample_out = r_out.sample_out;
    assign o_out.channel_on = r_out.channel_on;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in))
        else $error("pending beat lost or changed in input register");

    a_one_result_per_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("processed beat produced no result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid && out_free |=> !r_out_valid)
        else $error("result appeared without an input beat");

endmodule
